// ===== sv/word_token_classifier_macros.svh =====
// assertion macros used by the checker file
`ifndef WORD_TOKEN_CLASSIFIER_MACROS_SVH
`define WORD_TOKEN_CLASSIFIER_MACROS_SVH

// clocked assertion, quiet while reset is held
`define WTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define WTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `WTC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== sv/wtc_pkg.sv =====
// types, constants and keyword tables of the word token classifier
package wtc_pkg;

  localparam int unsigned NumberWidthDefault = 32;
  localparam int unsigned ValueWidth         = 32;
  localparam int unsigned ClassWidth         = 5;
  localparam int unsigned CountWidth         = 3;
  localparam int unsigned NumKeywords        = 5;

  localparam logic [7:0] AlphaLo    = 8'd65;
  localparam logic [7:0] AlphaHi    = 8'd122;
  localparam logic [7:0] CharZero   = "0";
  localparam logic [7:0] CharNine   = "9";
  localparam logic [7:0] CharColon  = ":";
  localparam logic [7:0] CharSlash  = "/";
  localparam logic [7:0] CharStar   = "*";
  localparam logic [7:0] CharEquals = "=";
  localparam logic [7:0] CharPlus   = "+";
  localparam logic [7:0] CharMinus  = "-";
  localparam logic [7:0] CharLParen = "(";
  localparam logic [7:0] CharRParen = ")";
  localparam logic [7:0] CharComma  = ",";
  localparam logic [7:0] CharSemi   = ";";

  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_IDENT = 3'd1,
    KIND_DIGIT = 3'd2,
    KIND_COLON = 3'd3,
    KIND_SLASH = 3'd4,
    KIND_OTHER = 3'd5
  } kind_e;

  typedef enum logic [ClassWidth-1:0] {
    TOK_ERROR     = 5'd0,
    TOK_BEGIN     = 5'd1,
    TOK_END       = 5'd2,
    TOK_IF        = 5'd3,
    TOK_THEN      = 5'd4,
    TOK_ELSE      = 5'd5,
    TOK_IDENT     = 5'd6,
    TOK_INTEGER   = 5'd7,
    TOK_PLUS      = 5'd8,
    TOK_MINUS     = 5'd9,
    TOK_STAR      = 5'd10,
    TOK_SLASH     = 5'd11,
    TOK_LPAREN    = 5'd12,
    TOK_RPAREN    = 5'd13,
    TOK_COMMA     = 5'd14,
    TOK_SEMICOLON = 5'd15,
    TOK_COLON     = 5'd16,
    TOK_ASSIGN    = 5'd17,
    TOK_EQUALS    = 5'd18,
    TOK_COMMENT   = 5'd19
  } token_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
    logic       last_char;
  } step_t;

  typedef struct packed {
    token_e                  token_class;
    logic [ValueWidth-1:0]   number_value;
    logic                    number_saturated;
  } result_t;

  function automatic logic [CountWidth-1:0] kw_len(input logic [2:0] k);
    logic [CountWidth-1:0] len;
    unique case (k)
      3'd0:    len = 3'd5;
      3'd1:    len = 3'd3;
      3'd2:    len = 3'd2;
      3'd3:    len = 3'd4;
      3'd4:    len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // keyword byte at a position below the keyword length
  function automatic logic [7:0] kw_char(input logic [2:0] k,
                                         input logic [CountWidth-1:0] pos);
    logic [39:0] text;
    logic [2:0]  idx;
    unique case (k)
      3'd0:    text = "begin";
      3'd1:    text = {"end", 16'h0000};
      3'd2:    text = {"if", 24'h000000};
      3'd3:    text = {"then", 8'h00};
      3'd4:    text = {"else", 8'h00};
      default: text = '0;
    endcase
    idx = 3'd4 - pos;
    return text[{idx, 3'b000} +: 8];
  endfunction

  function automatic token_e single_op(input logic [7:0] b);
    token_e t;
    unique case (b)
      CharPlus:   t = TOK_PLUS;
      CharMinus:  t = TOK_MINUS;
      CharStar:   t = TOK_STAR;
      CharLParen: t = TOK_LPAREN;
      CharRParen: t = TOK_RPAREN;
      CharComma:  t = TOK_COMMA;
      CharSemi:   t = TOK_SEMICOLON;
      CharEquals: t = TOK_EQUALS;
      default:    t = TOK_ERROR;
    endcase
    return t;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= AlphaLo) && (b <= AlphaHi);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CharZero) && (b <= CharNine);
  endfunction

endpackage

// ===== sv/word_token_classifier.sv =====
// a word's last byte waits in the byte register, then its result is registered in the result register
// throughput: one byte per cycle; the input stalls only while a held result blocks the next
//   last byte in the byte register
// internal accumulator is NUMBER_WIDTH bits; the 32-bit port shows it truncated or zero-extended
// reset: asynchronous active low, clears the byte and result valid flags and all word state
module word_token_classifier import wtc_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_byte_i,
  input  logic                  last_char_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ClassWidth-1:0] token_class_o,
  output logic [ValueWidth-1:0] number_value_o,
  output logic                  number_saturated_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       advance, in_fire;
  step_t      step;
  result_t    result;

  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  // a byte that ends no word never waits for the result register
  assign advance    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_byte_i;
      s1_last_q <= last_char_i;
    end
  end

  assign step.valid     = advance;
  assign step.char_byte = s1_char_q;
  assign step.last_char = s1_last_q;

  wtc_word_state #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_word_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .result_o(result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign token_class_o      = out_q.token_class;
  assign number_value_o     = out_q.number_value;
  assign number_saturated_o = out_q.number_saturated;

endmodule

// ===== sv/wtc_word_state.sv =====
// per-word state: first byte kind, keyword match bits, decimal accumulator
module wtc_word_state import wtc_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  step_t   step_i,
  output result_t result_o
);

  localparam int unsigned AccWidth = NUMBER_WIDTH + 4;

  kind_e                   kind_q, kind_d, kind_n;
  logic [7:0]              first_q, first_d, first_n;
  logic [CountWidth-1:0]   count_q, count_d, count_n;
  logic [NumKeywords-1:0]  hits_q, hits_d, hits_n;
  logic                    valid_q, valid_d, valid_n;
  logic [7:0]              second_q, second_d, second_n;
  logic [7:0]              prev_q, prev_d;
  logic [NUMBER_WIDTH-1:0] acc_q, acc_d, acc_n;
  logic                    clamp_q, clamp_d, clamp_n;

  logic [7:0]              b;
  logic [CountWidth-1:0]   pos;
  logic [AccWidth-1:0]     acc_ext, acc_x10;
  logic                    acc_over, acc_do;
  logic [NUMBER_WIDTH-1:0] acc_step;
  kind_e                   kind_new;
  token_e                  cls;
  logic [ValueWidth-1:0]   value_w;

  assign b   = step_i.char_byte;
  assign pos = count_q;

  always_comb begin
    priority if (is_alpha(b)) begin
      kind_new = KIND_IDENT;
    end else if (is_digit(b)) begin
      kind_new = KIND_DIGIT;
    end else if (b == CharColon) begin
      kind_new = KIND_COLON;
    end else if (b == CharSlash) begin
      kind_new = KIND_SLASH;
    end else begin
      kind_new = KIND_OTHER;
    end
  end

  // acc * 10 + digit, overflow when any bit lands above the field
  assign acc_ext  = AccWidth'(acc_q);
  assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + AccWidth'(b[3:0]);
  assign acc_over = |acc_x10[AccWidth-1:NUMBER_WIDTH];
  assign acc_step = (clamp_q || acc_over) ? '1 : acc_x10[NUMBER_WIDTH-1:0];

  // state after this byte, before the end-of-word clear
  always_comb begin
    kind_n   = kind_q;
    first_n  = first_q;
    valid_n  = valid_q;
    second_n = second_q;
    hits_n   = hits_q;
    acc_do   = 1'b0;
    if (pos == '0) begin
      first_n = b;
      kind_n  = kind_new;
      acc_do  = (kind_new == KIND_DIGIT);
    end else begin
      if (pos == CountWidth'(1)) begin
        second_n = b;
      end
      if (kind_q == KIND_IDENT) begin
        if (!(is_alpha(b) || is_digit(b))) begin
          valid_n = 1'b0;
        end
      end else if (kind_q == KIND_DIGIT) begin
        if (is_digit(b)) begin
          acc_do = 1'b1;
        end else begin
          valid_n = 1'b0;
        end
      end
    end
    for (int k = 0; k < NumKeywords; k++) begin
      if (pos >= kw_len(3'(k)) || kw_char(3'(k), pos) != b) begin
        hits_n[k] = 1'b0;
      end
    end
    acc_n   = acc_do ? acc_step : acc_q;
    clamp_n = acc_do ? (clamp_q || acc_over) : clamp_q;
    count_n = (pos == CountMax) ? CountMax : pos + CountWidth'(1);
  end

  always_comb begin
    kind_d   = kind_q;
    first_d  = first_q;
    count_d  = count_q;
    hits_d   = hits_q;
    valid_d  = valid_q;
    second_d = second_q;
    prev_d   = prev_q;
    acc_d    = acc_q;
    clamp_d  = clamp_q;
    if (step_i.valid) begin
      if (step_i.last_char) begin
        kind_d   = KIND_NONE;
        first_d  = '0;
        count_d  = '0;
        hits_d   = '1;
        valid_d  = 1'b1;
        second_d = '0;
        prev_d   = '0;
        acc_d    = '0;
        clamp_d  = 1'b0;
      end else begin
        kind_d   = kind_n;
        first_d  = first_n;
        count_d  = count_n;
        hits_d   = hits_n;
        valid_d  = valid_n;
        second_d = second_n;
        prev_d   = b;
        acc_d    = acc_n;
        clamp_d  = clamp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_NONE;
      first_q  <= '0;
      count_q  <= '0;
      hits_q   <= '1;
      valid_q  <= 1'b1;
      second_q <= '0;
      prev_q   <= '0;
      acc_q    <= '0;
      clamp_q  <= 1'b0;
    end else begin
      kind_q   <= kind_d;
      first_q  <= first_d;
      count_q  <= count_d;
      hits_q   <= hits_d;
      valid_q  <= valid_d;
      second_q <= second_d;
      prev_q   <= prev_d;
      acc_q    <= acc_d;
      clamp_q  <= clamp_d;
    end
  end

  // class of the word that ends with this byte
  always_comb begin
    cls = TOK_ERROR;
    unique case (kind_n)
      KIND_IDENT: begin
        if (valid_n) begin
          cls = TOK_IDENT;
          // lowest keyword index wins
          for (int k = NumKeywords - 1; k >= 0; k--) begin
            if (hits_n[k] && count_n == kw_len(3'(k))) begin
              cls = token_e'(ClassWidth'(k + 1));
            end
          end
        end
      end
      KIND_DIGIT: begin
        if (valid_n) begin
          cls = TOK_INTEGER;
        end
      end
      KIND_COLON: begin
        if (count_n == CountWidth'(1)) begin
          cls = TOK_COLON;
        end else if (count_n == CountWidth'(2) && second_n == CharEquals) begin
          cls = TOK_ASSIGN;
        end
      end
      KIND_SLASH: begin
        if (count_n == CountWidth'(1)) begin
          cls = TOK_SLASH;
        end else if (count_n >= CountWidth'(3) && second_n == CharStar &&
                     prev_q == CharStar && b == CharSlash) begin
          cls = TOK_COMMENT;
        end
      end
      KIND_OTHER: begin
        if (count_n == CountWidth'(1)) begin
          cls = single_op(first_n);
        end
      end
      default: cls = TOK_ERROR;
    endcase
  end

  if (NUMBER_WIDTH >= ValueWidth) begin : g_value_trunc
    assign value_w = acc_n[ValueWidth-1:0];
  end else begin : g_value_ext
    assign value_w = {{(ValueWidth - NUMBER_WIDTH){1'b0}}, acc_n};
  end

  assign result_o.token_class      = cls;
  assign result_o.number_value     = (cls == TOK_INTEGER) ? value_w : '0;
  assign result_o.number_saturated = (cls == TOK_INTEGER) && clamp_n;

endmodule

// ===== sv/wtc_checker.sv =====
// port-level checks of the word token classifier and their bind
`include "word_token_classifier_macros.svh"

module wtc_checker import wtc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [7:0]            char_byte_i,
  input logic                  last_char_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ClassWidth-1:0] token_class_o,
  input logic [ValueWidth-1:0] number_value_o,
  input logic                  number_saturated_o
);

  // a result waiting on the consumer stays put
  `WTC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(token_class_o) && $stable(number_value_o), "result changed while stalled")

  // value and clamp flag belong to integer words only
  `WTC_ASSERT(a_value_int_only, out_valid_o && (token_class_o != TOK_INTEGER) |-> (number_value_o == '0) && !number_saturated_o, "value on a non-integer word")

  // the input only stalls behind a held result
  `WTC_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output backpressure")

endmodule

bind word_token_classifier wtc_checker u_wtc_checker (.*);
